// ===== sv/hhic_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hhic_pkg
// Constants and match strings for the HTTP header image classifier.
// ----------------------------------------------------------------------------
package hhic_pkg;

  localparam int STATUS_LEN = 15;
  localparam int GIF_LEN    = 23;
  localparam int JPEG_LEN   = 24;
  localparam int POS_W      = 5;
  localparam logic [POS_W-1:0] LINE_MAX = 5'd31;

  localparam logic [7:0] BYTE_CR  = 8'd13;
  localparam logic [7:0] BYTE_LF  = 8'd10;
  localparam logic [7:0] PRINT_LO = 8'h20;
  localparam logic [7:0] PRINT_HI = 8'h7E;

  localparam logic [7:0] STATUS_TEXT [STATUS_LEN] = '{
    8'h48, 8'h54, 8'h54, 8'h50, 8'h2F, 8'h31, 8'h2E, 8'h31,
    8'h20, 8'h32, 8'h30, 8'h30, 8'h20, 8'h4F, 8'h4B
  };

  // "Content-Type: image/gif"
  localparam logic [7:0] GIF_TEXT [GIF_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h54, 8'h79, 8'h70, 8'h65, 8'h3A, 8'h20, 8'h69, 8'h6D,
    8'h61, 8'h67, 8'h65, 8'h2F, 8'h67, 8'h69, 8'h66
  };

  // "Content-Type: image/jpeg"
  localparam logic [7:0] JPEG_TEXT [JPEG_LEN] = '{
    8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
    8'h54, 8'h79, 8'h70, 8'h65, 8'h3A, 8'h20, 8'h69, 8'h6D,
    8'h61, 8'h67, 8'h65, 8'h2F, 8'h6A, 8'h70, 8'h65, 8'h67
  };

endpackage

// ===== sv/http_header_image_classifier.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_header_image_classifier
// Byte-wise HTTP header scan with status / gif / jpeg flags and body pass.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one payload byte per
//   transaction with packet_start and packet_end marks. packet_start clears
//   all scan state before its byte is used.
//   Output channel (out_valid / out_stall) returns exactly one result per
//   input byte: body_valid/body_byte for bytes past the blank header line,
//   the sticky is_http/is_gif/is_jpeg flags (including any line ended by this
//   byte), and payload_done echoing packet_end.
//   The result is registered: the scan state and result register update at the
//   accepting edge. Throughput is one byte per cycle while the receiver does
//   not stall, set by the single result register that the scan logic feeds.
//   When the receiver stalls, the result is held and in_stall is raised
//   only while the result register is full, so no transaction is lost.
//   Reset (rst, synchronous) empties the result register and returns the
//   scan state to the start of a header section.
// ----------------------------------------------------------------------------
module http_header_image_classifier (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       packet_start,
  input  logic       packet_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       body_valid,
  output logic [7:0] body_byte,
  output logic       is_http,
  output logic       is_gif,
  output logic       is_jpeg,
  output logic       payload_done
);

  localparam int PW = hhic_pkg::POS_W;

  logic [PW-1:0] line_pos, line_pos_next;
  logic status_alive, status_alive_next;
  logic gif_alive, gif_alive_next;
  logic jpeg_alive, jpeg_alive_next;
  logic last_eol, last_eol_next;
  logic pending_cr, pending_cr_next;
  logic in_body, in_body_next;
  logic http_seen, http_seen_next;
  logic gif_seen, gif_seen_next;
  logic jpeg_seen, jpeg_seen_next;
  logic body_next;

  logic accept;

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    logic [PW-1:0] p;
    logic [3:0]    s_idx;
    logic [PW-1:0] g_idx;
    logic [PW-1:0] j_idx;
    logic          s_in, g_in, j_in;
    logic          printable;

    // packet_start: begin from reset values
    line_pos_next     = packet_start ? '0   : line_pos;
    status_alive_next = packet_start ? 1'b1 : status_alive;
    gif_alive_next    = packet_start ? 1'b1 : gif_alive;
    jpeg_alive_next   = packet_start ? 1'b1 : jpeg_alive;
    last_eol_next     = packet_start ? 1'b0 : last_eol;
    pending_cr_next   = packet_start ? 1'b0 : pending_cr;
    in_body_next      = packet_start ? 1'b0 : in_body;
    http_seen_next    = packet_start ? 1'b0 : http_seen;
    gif_seen_next     = packet_start ? 1'b0 : gif_seen;
    jpeg_seen_next    = packet_start ? 1'b0 : jpeg_seen;
    body_next         = 1'b0;

    p     = line_pos_next;
    s_in  = p < PW'(hhic_pkg::STATUS_LEN);
    g_in  = p < PW'(hhic_pkg::GIF_LEN);
    j_in  = p < PW'(hhic_pkg::JPEG_LEN);
    s_idx = s_in ? p[3:0] : '0;
    g_idx = g_in ? p : '0;
    j_idx = j_in ? p : '0;
    printable = (data_byte >= hhic_pkg::PRINT_LO) && (data_byte <= hhic_pkg::PRINT_HI);

    if (in_body_next) begin
      body_next = 1'b1;
    end else if (pending_cr_next) begin
      pending_cr_next = 1'b0;
      if (data_byte == hhic_pkg::BYTE_LF) begin
        if (last_eol_next) in_body_next = 1'b1;
        if (status_alive_next && p == PW'(hhic_pkg::STATUS_LEN)) http_seen_next = 1'b1;
        if (gif_alive_next && !g_in) gif_seen_next = 1'b1;
        if (jpeg_alive_next && !j_in) jpeg_seen_next = 1'b1;
        line_pos_next     = '0;
        status_alive_next = 1'b1;
        gif_alive_next    = 1'b1;
        jpeg_alive_next   = 1'b1;
        last_eol_next     = 1'b1;
      end
    end else if (printable) begin
      status_alive_next = status_alive_next && s_in &&
                          (data_byte == hhic_pkg::STATUS_TEXT[s_idx]);
      if (g_in) gif_alive_next = gif_alive_next && (data_byte == hhic_pkg::GIF_TEXT[g_idx]);
      if (j_in) jpeg_alive_next = jpeg_alive_next && (data_byte == hhic_pkg::JPEG_TEXT[j_idx]);
      if (p < hhic_pkg::LINE_MAX) line_pos_next = p + PW'(1);
      last_eol_next = 1'b0;
    end else if (data_byte == hhic_pkg::BYTE_CR) begin
      pending_cr_next = 1'b1;
    end else begin
      last_eol_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pos     <= '0;
      status_alive <= 1'b1;
      gif_alive    <= 1'b1;
      jpeg_alive   <= 1'b1;
      last_eol     <= 1'b0;
      pending_cr   <= 1'b0;
      in_body      <= 1'b0;
      http_seen    <= 1'b0;
      gif_seen     <= 1'b0;
      jpeg_seen    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        line_pos     <= line_pos_next;
        status_alive <= status_alive_next;
        gif_alive    <= gif_alive_next;
        jpeg_alive   <= jpeg_alive_next;
        last_eol     <= last_eol_next;
        pending_cr   <= pending_cr_next;
        in_body      <= in_body_next;
        http_seen    <= http_seen_next;
        gif_seen     <= gif_seen_next;
        jpeg_seen    <= jpeg_seen_next;
        out_valid    <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      body_valid   <= body_next;
      body_byte    <= body_next ? data_byte : 8'h00;
      is_http      <= http_seen_next;
      is_gif       <= gif_seen_next;
      is_jpeg      <= jpeg_seen_next;
      payload_done <= packet_end;
    end
  end

  // a line end mark leaves the line state cleared
  a_eol_clean: assert property (@(posedge clk) disable iff (rst)
    last_eol |-> (line_pos == '0) && status_alive && gif_alive && jpeg_alive)
    else $error("line end mark with non-empty line state");

  // once in the body no CR is pending
  a_body_no_cr: assert property (@(posedge clk) disable iff (rst)
    !(in_body && pending_cr))
    else $error("pending CR inside body");

  // sticky flags only drop on a new payload
  a_http_sticky: assert property (@(posedge clk) disable iff (rst)
    (accept && !packet_start && http_seen) |=> http_seen)
    else $error("http flag dropped within payload");

  // a body result requires body state to be set
  a_body_state: assert property (@(posedge clk) disable iff (rst)
    (accept && body_next) |=> (in_body && out_valid && body_valid))
    else $error("body result without body state");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for http_header_image_classifier. A queue of payload
// bytes (short directed packets, then random header sections that are mostly
// well formed with noise, truncated and corrupted lines mixed in) feeds a
// clocked driver. A scan predictor runs on every accepted transaction, and a
// clocked monitor compares each result against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } in_txn_t;

  typedef struct packed {
    logic       body_valid;
    logic [7:0] body_byte;
    logic       is_http;
    logic       is_gif;
    logic       is_jpeg;
    logic       payload_done;
  } scan_result_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] data_byte = 8'd0;
  logic       packet_start = 1'b0;
  logic       packet_end = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic       body_valid;
  logic [7:0] body_byte;
  logic       is_http;
  logic       is_gif;
  logic       is_jpeg;
  logic       payload_done;

  in_txn_t      txn_q[$];
  scan_result_t result_q[$];
  logic [7:0]   pkt[$];
  int           n_taken = 0;
  int           n_bad = 0;

  // predictor state
  logic [hhic_pkg::POS_W-1:0] pos;
  logic status_ok, gif_ok, jpeg_ok;
  logic after_crlf, cr_wait, body_on;
  logic saw_http, saw_gif, saw_jpeg;

  http_header_image_classifier DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .packet_start (packet_start),
    .packet_end   (packet_end),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .body_valid   (body_valid),
    .body_byte    (body_byte),
    .is_http      (is_http),
    .is_gif       (is_gif),
    .is_jpeg      (is_jpeg),
    .payload_done (payload_done)
  );

  always #2 clk = ~clk;

  task automatic new_line();
    pos = '0;
    status_ok = 1'b1;
    gif_ok = 1'b1;
    jpeg_ok = 1'b1;
  endtask

  task automatic clear_scan();
    new_line();
    after_crlf = 1'b0;
    cr_wait = 1'b0;
    body_on = 1'b0;
    saw_http = 1'b0;
    saw_gif = 1'b0;
    saw_jpeg = 1'b0;
  endtask

  task automatic predict_scan(input logic [7:0] c, input logic first, input logic last);
    scan_result_t r;
    int p;
    r = '0;
    if (first) clear_scan();
    if (body_on) begin
      r.body_valid = 1'b1;
      r.body_byte = c;
    end else if (cr_wait) begin
      cr_wait = 1'b0;
      if (c == hhic_pkg::BYTE_LF) begin
        if (after_crlf) body_on = 1'b1;
        if (status_ok && pos == hhic_pkg::STATUS_LEN) saw_http = 1'b1;
        if (gif_ok && pos >= hhic_pkg::GIF_LEN) saw_gif = 1'b1;
        if (jpeg_ok && pos >= hhic_pkg::JPEG_LEN) saw_jpeg = 1'b1;
        new_line();
        after_crlf = 1'b1;
      end
    end else if (c >= hhic_pkg::PRINT_LO && c <= hhic_pkg::PRINT_HI) begin
      p = pos;
      if (p >= hhic_pkg::STATUS_LEN) status_ok = 1'b0;
      else if (c != hhic_pkg::STATUS_TEXT[p]) status_ok = 1'b0;
      if (p < hhic_pkg::GIF_LEN && c != hhic_pkg::GIF_TEXT[p]) gif_ok = 1'b0;
      if (p < hhic_pkg::JPEG_LEN && c != hhic_pkg::JPEG_TEXT[p]) jpeg_ok = 1'b0;
      if (pos < hhic_pkg::LINE_MAX) pos = pos + 1'b1;
      after_crlf = 1'b0;
    end else if (c == hhic_pkg::BYTE_CR) begin
      cr_wait = 1'b1;
    end else begin
      after_crlf = 1'b0;
    end
    r.is_http = saw_http;
    r.is_gif = saw_gif;
    r.is_jpeg = saw_jpeg;
    r.payload_done = last;
    result_q.push_back(r);
  endtask

  // ---- stimulus building ----
  task automatic put_crlf();
    pkt.push_back(hhic_pkg::BYTE_CR);
    pkt.push_back(hhic_pkg::BYTE_LF);
  endtask

  // stray non-printable byte, or a CR whose next byte gets swallowed
  task automatic put_noise();
    logic [7:0] b;
    if ($urandom_range(0, 1) == 0) begin
      do b = $urandom_range(0, 255);
      while ((b >= hhic_pkg::PRINT_LO && b <= hhic_pkg::PRINT_HI) || b == hhic_pkg::BYTE_CR);
      pkt.push_back(b);
    end else begin
      pkt.push_back(hhic_pkg::BYTE_CR);
      do b = $urandom_range(0, 255);
      while (b == hhic_pkg::BYTE_LF);
      pkt.push_back(b);
    end
  endtask

  task automatic put_line(input string s);
    for (int i = 0; i < s.len(); i++) begin
      if ($urandom_range(0, 29) == 0) put_noise();
      pkt.push_back(s[i]);
    end
    case ($urandom_range(0, 19))
      0: pkt.push_back(hhic_pkg::BYTE_LF);
      1: begin
        pkt.push_back(hhic_pkg::BYTE_CR);
        put_crlf();
      end
      default: put_crlf();
    endcase
  endtask

  task automatic put_header();
    string s;
    int n;
    case ($urandom_range(0, 7))
      0: s = "HTTP/1.1 200 OK";
      1: s = "Content-Type: image/gif";
      2: s = "Content-Type: image/jpeg";
      3: s = $urandom_range(0, 1) ? "Content-Type: image/gif; x=1"
                                  : "Content-Type: image/jpeg; q=9";
      4: begin
        s = "HTTP/1.1 200 OK";
        case ($urandom_range(0, 2))
          0: s.putc($urandom_range(0, hhic_pkg::STATUS_LEN - 1),
                    $urandom_range(hhic_pkg::PRINT_LO, hhic_pkg::PRINT_HI));
          1: s = s.substr(0, $urandom_range(0, hhic_pkg::STATUS_LEN - 2));
          default: s = {s, " "};
        endcase
      end
      5: begin
        s = $urandom_range(0, 1) ? "Content-Type: image/gif" : "Content-Type: image/jpeg";
        if ($urandom_range(0, 1) == 0) s = s.substr(0, s.len() - 2 - $urandom_range(0, 3));
        else s.putc($urandom_range(0, s.len() - 1),
                    $urandom_range(hhic_pkg::PRINT_LO, hhic_pkg::PRINT_HI));
      end
      6: begin
        // long lines can reach the position saturation
        s = "";
        n = $urandom_range(1, 40);
        repeat (n) s = {s, "a"};
        for (int i = 0; i < n; i++)
          s.putc(i, $urandom_range(hhic_pkg::PRINT_LO, hhic_pkg::PRINT_HI));
      end
      default: s = "Server: x";
    endcase
    put_line(s);
  endtask

  task automatic ship_packet(input bit with_start);
    in_txn_t t;
    for (int i = 0; i < pkt.size(); i++) begin
      t.data = pkt[i];
      t.first = with_start && i == 0;
      t.last = i == pkt.size() - 1;
      txn_q.push_back(t);
    end
    pkt.delete();
  endtask

  task automatic gen_packet();
    in_txn_t t;
    if ($urandom_range(0, 9) == 0) begin
      // raw noise with marks anywhere
      repeat ($urandom_range(1, 20)) begin
        if ($urandom_range(0, 3) == 0)
          t.data = $urandom_range(0, 1) ? hhic_pkg::BYTE_CR : hhic_pkg::BYTE_LF;
        else t.data = $urandom_range(0, 255);
        t.first = $urandom_range(0, 7) == 0;
        t.last = $urandom_range(0, 7) == 0;
        txn_q.push_back(t);
      end
    end else begin
      repeat ($urandom_range(1, 4)) put_header();
      if ($urandom_range(0, 3) != 0) begin
        if ($urandom_range(0, 7) == 0) put_noise();
        put_crlf();
        repeat ($urandom_range(0, 10)) pkt.push_back($urandom_range(0, 255));
      end
      ship_packet($urandom_range(0, 9) != 0);
    end
  endtask

  function automatic bit take_break();
    if (n_taken >= 250 && n_taken < 400) return 1'b0;
    return $urandom_range(0, 99) < 34;
  endfunction

  // ---- driver ----
  always @(posedge clk) begin
    in_txn_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_scan(data_byte, packet_start, packet_end);
        n_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (txn_q.size() != 0 && !take_break()) begin
          nxt = txn_q.pop_front();
          in_valid <= 1'b1;
          data_byte <= nxt.data;
          packet_start <= nxt.first;
          packet_end <= nxt.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---- monitor ----
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      n_bad++;
      if (n_bad <= 10)
        $display("tb: mismatch %s expected %h actual %h at %0t", name, want, got, $realtime);
    end
  endtask

  always @(posedge clk) begin
    scan_result_t w;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (result_q.size() == 0) begin
          n_bad++;
          if (n_bad <= 10) $display("tb: unexpected result at %0t", $realtime);
        end else begin
          w = result_q.pop_front();
          check_field("body_valid", w.body_valid, body_valid);
          check_field("body_byte", w.body_byte, body_byte);
          check_field("is_http", w.is_http, is_http);
          check_field("is_gif", w.is_gif, is_gif);
          check_field("is_jpeg", w.is_jpeg, is_jpeg);
          check_field("payload_done", w.payload_done, payload_done);
        end
      end
      out_stall <= take_break();
    end
  end

  initial begin
    clear_scan();
    // extremes, stray controls, CR swallowing another CR and a printable
    pkt = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h20, 8'h7E, 8'h1F,
            hhic_pkg::BYTE_CR, hhic_pkg::BYTE_CR, hhic_pkg::BYTE_CR, 8'h41,
            hhic_pkg::BYTE_CR, hhic_pkg::BYTE_LF, hhic_pkg::BYTE_CR, hhic_pkg::BYTE_LF,
            8'h00, 8'hFF, hhic_pkg::BYTE_CR, hhic_pkg::BYTE_LF};
    ship_packet(1'b1);
    // CR as last byte, then a packet without start picks up the pending CR
    pkt = '{8'h58, hhic_pkg::BYTE_CR};
    ship_packet(1'b1);
    pkt = '{hhic_pkg::BYTE_LF, hhic_pkg::BYTE_CR, hhic_pkg::BYTE_LF, 8'h5A};
    ship_packet(1'b0);
    begin
      int base;
      base = txn_q.size();
      while (txn_q.size() < base + 650) gen_packet();
    end
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    while (txn_q.size() != 0 || in_valid) @(posedge clk);
    while (result_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (result_q.size() != 0) n_bad++;
    if (n_bad == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
